// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define WAT_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, clocked on clock, off during reset
`define WAT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/wat_pkg.sv =====
`default_nettype none
package wat_pkg;

   localparam int MH_W   = 6;
   localparam int TAU_W  = 14;
   localparam int OMG_W  = 16;
   localparam int HC_W   = 6;
   localparam int QBITS  = 16;
   localparam int QIDX_W = 4;
   localparam int DK_W   = 5;

   localparam logic [TAU_W-1:0] TAU_ONE   = 14'd256;
   localparam logic [TAU_W-1:0] TAU_MAX   = 14'd16383;
   localparam logic [QBITS-1:0] TAU_SAT_Q = 16'd16127;
   localparam logic [OMG_W-1:0] ONE_Q15   = 16'd32768;
   localparam logic [MH_W-1:0]  MH_RESET  = 6'd2;
   localparam logic [23:0]      OMG_NUM   = 24'h800000;

   localparam logic [1:0] PASS_SUM = 2'd0;
   localparam logic [1:0] PASS_DEV = 2'd1;
   localparam logic [1:0] PASS_COV = 2'd2;

   typedef struct packed {
      logic       push;
      logic       pass_start;
      logic [1:0] pass_kind;
      logic       lag_first;
      logic       lag_next;
      logic       acc_add;
      logic       tau_one;
      logic       div_tau;
      logic       div_omega;
      logic       tau_load;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic pass_busy;
      logic div_busy;
      logic var_zero;
      logic cov_pos;
      logic lag_last;
      logic est;
   } stat_type;

endpackage
`default_nettype wire

// ===== rtl/wat_if.sv =====
`default_nettype none
interface wat_req_if #(parameter int SAMPLE_BITS = 16);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface wat_rsp_if;
   logic        valid;
   logic        ready;
   logic [13:0] tau;
   logic [15:0] omega;
   logic        estimable;
   logic [5:0]  held_count;
   modport source (output valid, output tau, output omega, output estimable,
                   output held_count, input ready);
   modport sink (input valid, input tau, input omega, input estimable,
                 input held_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/wat_datapath.sv =====
`default_nettype none
module wat_datapath #(
   parameter int WINDOW      = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [wat_pkg::MH_W-1:0]  csr_wdata,
   input  logic [SAMPLE_BITS-1:0]    sample,
   input  wat_pkg::cmd_type          cmd,
   output wat_pkg::stat_type         stat,
   output logic [wat_pkg::TAU_W-1:0] tau,
   output logic [wat_pkg::OMG_W-1:0] omega,
   output logic                      estimable,
   output logic [wat_pkg::HC_W-1:0]  held_count
);
   import wat_pkg::*;

   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int PTR_W  = $clog2(WINDOW);
   localparam int SUM_W  = SAMPLE_BITS + CNT_W;
   localparam int DEV_W  = SUM_W + 1;
   localparam int PROD_W = 2 * DEV_W;
   localparam int ACC_W  = PROD_W + 2 * CNT_W;
   localparam int DIV_W  = ACC_W + 10 + QBITS;
   localparam int EW     = (CNT_W > MH_W) ? CNT_W : MH_W;
   localparam logic [PTR_W:0]   WIN_P = (PTR_W + 1)'(WINDOW);
   localparam logic [CNT_W-1:0] WIN_C = CNT_W'(WINDOW);

   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                 input logic [PTR_W-1:0] b);
      logic [PTR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= WIN_P) s = s - WIN_P;
      return s[PTR_W-1:0];
   endfunction

   logic [SAMPLE_BITS-1:0]  smem [WINDOW];
   logic signed [DEV_W-1:0] dmem [WINDOW];

   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [PTR_W-1:0] optr_ff, optr_in;
   logic [MH_W-1:0]  mh_ff;
   logic [PTR_W-1:0] push_addr;

   logic             busy_ff, busy_in;
   logic [1:0]       kind_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             v1_ff, v2_ff, v3_ff;
   logic             issue;
   logic [PTR_W-1:0] saddr, ia, ib, k_d1_ff;
   logic [CNT_W-1:0] cnt_lag;

   logic [SAMPLE_BITS-1:0]   x_rd_ff;
   logic signed [DEV_W-1:0]  da_ff, db_ff, d_ff, d_in;
   logic [SUM_W-1:0]         nx;
   logic signed [PROD_W-1:0] sq_ff, cprod_ff;
   logic [SUM_W-1:0]         sum_ff;
   logic signed [ACC_W-1:0]  var_ff, cov_ff, acc_ff;
   logic [CNT_W-1:0]         lag_ff;
   logic [TAU_W-1:0]         tau_ff;

   logic [DIV_W-1:0]  div_rem_ff, div_den_ff, div_num, div_den;
   logic [QBITS-1:0]  div_q_ff;
   logic              div_ovf_ff, div_busy_ff, div_ge;
   logic [DK_W-1:0]   div_k_ff;
   logic [EW-1:0]     need;
   logic              est;

   // window push
   always_comb begin
      fill_in = fill_ff;
      optr_in = optr_ff;
      if (fill_ff < WIN_C) begin
         push_addr = wrap_add(optr_ff, fill_ff[PTR_W-1:0]);
         fill_in   = fill_ff + 1'b1;
      end else begin
         push_addr = optr_ff;
         optr_in   = wrap_add(optr_ff, PTR_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         optr_ff <= '0;
         mh_ff   <= MH_RESET;
      end else begin
         if (cmd.push) begin
            fill_ff <= fill_in;
            optr_ff <= optr_in;
         end
         if (csr_we) mh_ff <= csr_wdata;
      end
   end

   // pass sequencing
   assign issue   = busy_ff && (cnt_ff < fill_ff);
   assign cnt_lag = cnt_ff - lag_ff;
   assign saddr   = wrap_add(optr_ff, cnt_ff[PTR_W-1:0]);
   assign ia      = cnt_ff[PTR_W-1:0];
   assign ib      = cnt_lag[PTR_W-1:0];
   assign busy_in = cmd.pass_start ? 1'b1 : (busy_ff && (issue || v1_ff || v2_ff || v3_ff));

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.pass_start) cnt_in = (cmd.pass_kind == PASS_COV) ? lag_ff : '0;
      else if (issue)     cnt_in = cnt_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         v1_ff   <= issue;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      k_d1_ff <= ia;
      if (cmd.pass_start) kind_ff <= cmd.pass_kind;
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.push) smem[push_addr] <= sample;
      x_rd_ff <= smem[saddr];
   end

   always_ff @(posedge clock) begin
      if (v1_ff && kind_ff == PASS_DEV) dmem[k_d1_ff] <= d_in;
      da_ff <= dmem[ia];
      db_ff <= dmem[ib];
   end

   // arithmetic
   assign nx   = SUM_W'(fill_ff) * SUM_W'(x_rd_ff);
   assign d_in = signed'({1'b0, nx}) - signed'({1'b0, sum_ff});

   always_ff @(posedge clock) begin
      d_ff     <= d_in;
      sq_ff    <= d_ff * d_ff;
      cprod_ff <= da_ff * db_ff;
      if (cmd.pass_start && cmd.pass_kind == PASS_SUM) sum_ff <= '0;
      else if (v1_ff && kind_ff == PASS_SUM) sum_ff <= sum_ff + SUM_W'(x_rd_ff);
      if (cmd.pass_start && cmd.pass_kind == PASS_DEV) var_ff <= '0;
      else if (v3_ff && kind_ff == PASS_DEV) var_ff <= var_ff + ACC_W'(sq_ff);
      if (cmd.pass_start && cmd.pass_kind == PASS_COV) cov_ff <= '0;
      else if (v2_ff && kind_ff == PASS_COV) cov_ff <= cov_ff + ACC_W'(cprod_ff);
      if (cmd.lag_first) begin
         acc_ff <= '0;
         lag_ff <= CNT_W'(1);
      end else begin
         if (cmd.acc_add)  acc_ff <= acc_ff + cov_ff;
         if (cmd.lag_next) lag_ff <= lag_ff + 1'b1;
      end
   end

   // shared restoring divider, one quotient bit a cycle
   always_comb begin
      if (cmd.div_tau) begin
         div_num = (DIV_W'($unsigned(acc_ff)) << 9) + DIV_W'($unsigned(var_ff >>> 1));
         div_den = DIV_W'($unsigned(var_ff));
      end else begin
         div_num = DIV_W'(OMG_NUM) + DIV_W'(tau_ff[TAU_W-1:1]);
         div_den = DIV_W'(tau_ff);
      end
   end

   assign div_ge = div_rem_ff >= div_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (cmd.div_tau || cmd.div_omega) begin
         div_busy_ff <= 1'b1;
      end else if (div_busy_ff && div_k_ff == '0) begin
         div_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_tau || cmd.div_omega) begin
         div_rem_ff <= div_num;
         div_den_ff <= div_den << QBITS;
         div_q_ff   <= '0;
         div_ovf_ff <= 1'b0;
         div_k_ff   <= DK_W'(QBITS);
      end else if (div_busy_ff) begin
         if (div_ge) begin
            if (div_k_ff == DK_W'(QBITS)) begin
               div_ovf_ff <= 1'b1;
            end else begin
               div_rem_ff <= div_rem_ff - div_den_ff;
               div_q_ff[div_k_ff[QIDX_W-1:0]] <= 1'b1;
            end
         end
         div_den_ff <= div_den_ff >> 1;
         div_k_ff   <= div_k_ff - 1'b1;
      end
   end

   // tau and result
   assign need = (mh_ff < MH_W'(2)) ? EW'(2) : EW'(mh_ff);
   assign est  = EW'(fill_ff) >= need;

   always_ff @(posedge clock) begin
      if (cmd.tau_one) begin
         tau_ff <= TAU_ONE;
      end else if (cmd.tau_load) begin
         if (div_ovf_ff || div_q_ff > TAU_SAT_Q) tau_ff <= TAU_MAX;
         else tau_ff <= TAU_W'(QBITS'(TAU_ONE) + div_q_ff);
      end
      if (cmd.load_out) begin
         tau        <= tau_ff;
         omega      <= est ? div_q_ff : ONE_Q15;
         estimable  <= est;
         held_count <= HC_W'(fill_ff);
      end
   end

   assign stat.pass_busy = busy_ff;
   assign stat.div_busy  = div_busy_ff;
   assign stat.var_zero  = (var_ff == '0);
   assign stat.cov_pos   = !cov_ff[ACC_W-1] && (cov_ff != '0);
   assign stat.lag_last  = (lag_ff == fill_ff - 1'b1);
   assign stat.est       = est;

endmodule
`default_nettype wire

// ===== rtl/wat_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"
module wat_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  wat_pkg::stat_type stat,
   output wat_pkg::cmd_type  cmd
);
   import wat_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_PUSH   = 4'd1;
   localparam logic [3:0] S_SUMW   = 4'd2;
   localparam logic [3:0] S_DEVW   = 4'd3;
   localparam logic [3:0] S_VCHK   = 4'd4;
   localparam logic [3:0] S_COVS   = 4'd5;
   localparam logic [3:0] S_COVW   = 4'd6;
   localparam logic [3:0] S_COVCHK = 4'd7;
   localparam logic [3:0] S_TAUS   = 4'd8;
   localparam logic [3:0] S_TAUW   = 4'd9;
   localparam logic [3:0] S_OMS    = 4'd10;
   localparam logic [3:0] S_OMW    = 4'd11;
   localparam logic [3:0] S_OUT    = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.push = 1'b1;
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            cmd.pass_start = 1'b1;
            cmd.pass_kind  = PASS_SUM;
            state_in       = S_SUMW;
         end
         S_SUMW: begin
            if (!stat.pass_busy) begin
               cmd.pass_start = 1'b1;
               cmd.pass_kind  = PASS_DEV;
               state_in       = S_DEVW;
            end
         end
         S_DEVW: begin
            if (!stat.pass_busy) state_in = S_VCHK;
         end
         S_VCHK: begin
            if (stat.var_zero) begin
               cmd.tau_one = 1'b1;
               state_in    = S_OMS;
            end else begin
               cmd.lag_first = 1'b1;
               state_in      = S_COVS;
            end
         end
         S_COVS: begin
            cmd.pass_start = 1'b1;
            cmd.pass_kind  = PASS_COV;
            state_in       = S_COVW;
         end
         S_COVW: begin
            if (!stat.pass_busy) state_in = S_COVCHK;
         end
         S_COVCHK: begin
            cmd.acc_add = stat.cov_pos;
            if (stat.cov_pos && !stat.lag_last) begin
               cmd.lag_next = 1'b1;
               state_in     = S_COVS;
            end else begin
               state_in = S_TAUS;
            end
         end
         S_TAUS: begin
            cmd.div_tau = 1'b1;
            state_in    = S_TAUW;
         end
         S_TAUW: begin
            if (!stat.div_busy) begin
               cmd.tau_load = 1'b1;
               state_in     = S_OMS;
            end
         end
         S_OMS: begin
            if (stat.est) begin
               cmd.div_omega = 1'b1;
               state_in      = S_OMW;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OMW: begin
            if (!stat.div_busy) state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `WAT_ASSERT_NEXT(a_accept_blocks, req_valid && req_ready, !req_ready)
   `WAT_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, rsp_valid)
   `WAT_ASSERT_NEXT(a_div_runs, cmd.div_tau || cmd.div_omega, stat.div_busy)
   `WAT_ASSERT_IMPL(a_load_when_free, cmd.load_out && rsp_valid, rsp_ready)

endmodule
`default_nettype wire

// ===== rtl/windowed_autocorrelation_time.sv =====
// from accept to result the block runs a sum pass and a deviation pass over the held samples,
// then one multiply-accumulate pass over the deviation memory per evaluated lag, a tau division
// and an omega division; not estimable skips the omega division, zero variance also skips the
// lag passes and the tau division; one transaction in flight, no new sample is accepted until
// the result is loaded
// synchronous active-high reset empties the window and sets the minimum history register to 2
`default_nettype none
module windowed_autocorrelation_time #(
   parameter int WINDOW      = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   wat_req_if.sink                  req_if,
   wat_rsp_if.source                rsp_if,
   input  logic                     csr_we,
   input  logic [wat_pkg::MH_W-1:0] csr_wdata
);
   import wat_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   wat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   wat_datapath #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .sample     (req_if.sample),
      .cmd        (cmd),
      .stat       (stat),
      .tau        (rsp_if.tau),
      .omega      (rsp_if.omega),
      .estimable  (rsp_if.estimable),
      .held_count (rsp_if.held_count)
   );

endmodule
`default_nettype wire

// ===== verif/wat_tb_if.sv =====
`timescale 1ns / 100ps
`default_nettype none
interface wat_tb_csr_if;
   logic                     we;
   logic [wat_pkg::MH_W-1:0] wdata;
endinterface
`default_nettype wire

// ===== verif/windowed_autocorrelation_time_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module windowed_autocorrelation_time_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_sample,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [13:0] rsp_tau,
   input  logic [15:0] rsp_omega,
   input  logic        rsp_estimable,
   input  logic [5:0]  rsp_held_count,
   input  logic        csr_we,
   input  logic [5:0]  csr_wdata,
   output int          fail_count,
   output int          pending_count
);
   import wat_pkg::*;

   typedef struct packed {
      logic [13:0] tau;
      logic [15:0] omega;
      logic        estimable;
      logic [5:0]  held_count;
   } tau_result_type;

   logic [15:0] hist_window [32];
   int unsigned hist_fill;
   int unsigned hist_head;
   logic [5:0]  min_hist;
   tau_result_type expected_taus [$];

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic tau_result_type predict_tau(input logic [15:0] x);
      tau_result_type r;
      longint      vals [32];
      longint      dev [32];
      longint      sum, cov;
      longint unsigned var_s, acc, q, tau, need;
      int unsigned n;
      if (hist_fill < 32) begin
         hist_window[(hist_head + hist_fill) % 32] = x;
         hist_fill++;
      end else begin
         hist_window[hist_head] = x;
         hist_head = (hist_head + 1) % 32;
      end
      n = hist_fill;
      sum = 0;
      for (int k = 0; k < n; k++) begin
         vals[k] = hist_window[(hist_head + k) % 32];
         sum += vals[k];
      end
      for (int k = 0; k < n; k++) dev[k] = longint'(n) * vals[k] - sum;
      tau = 256;
      if (n >= 2) begin
         var_s = 0;
         for (int k = 0; k < n; k++) var_s += dev[k] * dev[k];
         if (var_s != 0) begin
            acc = 0;
            for (int lag = 1; lag < n; lag++) begin
               cov = 0;
               for (int i = lag; i < n; i++) cov += dev[i] * dev[i - lag];
               if (cov <= 0) break;
               acc += cov;
            end
            q = (512 * acc + var_s / 2) / var_s;
            tau = (q > 16383 - 256) ? 16383 : 256 + q;
         end
      end
      need = (min_hist < 2) ? 2 : min_hist;
      r.tau = tau[13:0];
      r.estimable = (n >= need);
      r.omega = r.estimable ? 16'(((64'd1 << 23) + tau / 2) / tau) : ONE_Q15;
      r.held_count = 6'(n);
      return r;
   endfunction

   always @(posedge clock) begin
      tau_result_type w;
      tau_result_type p;
      if (reset) begin
         foreach (hist_window[i]) hist_window[i] = '0;
         hist_fill = 0;
         hist_head = 0;
         min_hist = MH_RESET;
         expected_taus.delete();
         fail_count = 0;
      end else begin
         if (csr_we) min_hist = csr_wdata;
         if (req_valid && req_ready) begin
            p = predict_tau(req_sample);
            expected_taus.insert(expected_taus.size(), p);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_taus.size() == 0) begin
               report_mismatch("unexpected transaction", 1, 0);
            end else begin
               w = expected_taus[0];
               expected_taus.delete(0);
               if (rsp_tau !== w.tau) report_mismatch("tau", rsp_tau, w.tau);
               if (rsp_omega !== w.omega) report_mismatch("omega", rsp_omega, w.omega);
               if (rsp_estimable !== w.estimable)
                  report_mismatch("estimable", rsp_estimable, w.estimable);
               if (rsp_held_count !== w.held_count)
                  report_mismatch("held_count", rsp_held_count, w.held_count);
            end
         end
      end
      pending_count = expected_taus.size();
   end
endmodule
`default_nettype wire

// ===== verif/windowed_autocorrelation_time_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module windowed_autocorrelation_time_test;
   import wat_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   req_idle_pct;
   int   rsp_idle_pct;

   wat_req_if #(.SAMPLE_BITS(16)) req_if ();
   wat_rsp_if rsp_if ();
   wat_tb_csr_if csr_if ();

   windowed_autocorrelation_time u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if.sink),
      .rsp_if    (rsp_if.source),
      .csr_we    (csr_if.we),
      .csr_wdata (csr_if.wdata)
   );

   windowed_autocorrelation_time_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_sample     (req_if.sample),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_tau        (rsp_if.tau),
      .rsp_omega      (rsp_if.omega),
      .rsp_estimable  (rsp_if.estimable),
      .rsp_held_count (rsp_if.held_count),
      .csr_we         (csr_if.we),
      .csr_wdata      (csr_if.wdata),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #250ms;
      $display("windowed_autocorrelation_time verification failed");
      $finish;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic send_sample(input logic [15:0] s);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.sample <= s;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_history_floor(input logic [5:0] v);
      req_if.valid <= 1'b0;
      wait (pending_count == 0);
      repeat (800) @(negedge clock);
      csr_if.we <= 1'b1;
      csr_if.wdata <= v;
      @(negedge clock);
      csr_if.we <= 1'b0;
   endtask

   function automatic logic [15:0] rand_sample(input int mode, input logic [15:0] prev,
                                               input int idx);
      case (mode)
         0: return 16'($urandom);
         1: return prev + 16'($urandom_range(2000)) - 16'd1000;
         2: return idx[0] ? 16'hffff : 16'h0000;
         3: return 16'(idx * 1000);
         default: return 16'($urandom_range(3));
      endcase
   endfunction

   initial begin
      logic [15:0] prev;
      int          mode;
      logic [5:0]  mh_list [6];
      mh_list = '{6'd0, 6'd1, 6'd32, 6'd63, 6'd17, 6'd5};
      req_idle_pct = 26;
      rsp_idle_pct = 63;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.sample = '0;
      csr_if.we = 1'b0;
      csr_if.wdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_sample(16'h0000);
      send_sample(16'h0000);
      send_sample(16'hffff);
      send_sample(16'h0000);
      send_sample(16'hffff);
      for (int i = 0; i < 8; i++) send_sample(16'(i * 8000));
      for (int i = 0; i < 6; i++) send_sample(16'h1234);
      send_sample(16'h5555);
      send_sample(16'haaaa);
      prev = 16'h8000;
      for (int ph = 0; ph < 6; ph++) begin
         set_history_floor(mh_list[ph]);
         if (ph == 2) begin
            req_idle_pct = 63;
            rsp_idle_pct = 26;
         end else if (ph == 4) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         for (int i = 0; i < 165; i++) begin
            if (i % 40 == 0) mode = $urandom_range(4);
            prev = rand_sample(mode, prev, i);
            send_sample(prev);
         end
      end
      req_if.valid <= 1'b0;
      wait (pending_count == 0);
      repeat (800) @(posedge clock);
      if (fail_count == 0) begin
         $display("windowed_autocorrelation_time verification clean");
      end else begin
         $display("windowed_autocorrelation_time verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
